[design/audio_peak_rms_meter_defines.svh]
// assertion macros for the audio level meter
`ifndef AUDIO_PEAK_RMS_METER_DEFINES_SVH
`define AUDIO_PEAK_RMS_METER_DEFINES_SVH

`ifndef SYNTH
`define APM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apm check failed");
`define APM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apm check failed");
`else
`define APM_ASSERT_IMPLIES(lbl, ante, cons)
`define APM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/apm_pkg.sv]
`default_nettype none
package apm_pkg;

  // sample format codes
  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S32 = 3'd2;
  localparam logic [2:0] FMT_F32 = 3'd3;
  localparam logic [2:0] FMT_F64 = 3'd4;

  localparam int          PADDR_W           = 3;
  localparam logic        REG_SAMPLE_FORMAT = 1'b0;

  localparam logic [31:0] FULL_SCALE = 32'h8000_0000;
  localparam logic [16:0] MAX_VALUES = 17'd65536;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int DIV_STEPS  = 49;
  localparam int SQRT_STEPS = 17;
  localparam int STEP_W     = 6;

  typedef struct packed {
    logic [31:0] mag;
    logic        ok;
    logic        last;
  } mag_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ACC,
    BK_PREP,
    BK_DIV,
    BK_ROOT,
    BK_OUT
  } back_state_e;

endpackage
`default_nettype wire

[design/apm_front.sv]
`default_nettype none
module apm_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [2:0]           sample_format_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [63:0]          sample_bits_i,
  input  wire                  last_value_i,
  output logic                 push_valid_o,
  input  wire                  push_ready_i,
  output apm_pkg::mag_item_t   push_item_o
);
  import apm_pkg::*;

  logic       stg_valid_q, stg_valid_d;
  mag_item_t  stg_item_q;
  mag_item_t  dec_item;
  logic       accept;

  // integer formats
  logic [7:0]  u8_raw, u8_mag;
  logic [15:0] s16_raw, s16_mag;
  logic [31:0] s32_raw, s32_mag;
  // float32
  logic [7:0]  f32_ex, f32_rsh;
  logic [2:0]  f32_lsh;
  logic [23:0] f32_m;
  logic [31:0] f32_mag;
  // float64
  logic [10:0] f64_ex, f64_rsh;
  logic [52:0] f64_m;
  logic [52:0] f64_shifted;
  logic [31:0] f64_mag;

  always_comb begin
    u8_raw  = sample_bits_i[7:0];
    u8_mag  = u8_raw[7] ? {1'b0, u8_raw[6:0]} : (8'd128 - u8_raw);
    s16_raw = sample_bits_i[15:0];
    s16_mag = s16_raw[15] ? (~s16_raw + 16'd1) : s16_raw;
    s32_raw = sample_bits_i[31:0];
    s32_mag = s32_raw[31] ? (~s32_raw + 32'd1) : s32_raw;
  end

  always_comb begin
    f32_ex  = sample_bits_i[30:23];
    f32_m   = {(f32_ex != 8'd0), sample_bits_i[22:0]};
    f32_lsh = 3'(f32_ex - 8'd119);
    f32_rsh = 8'd119 - f32_ex;
    if (f32_ex >= 8'd127) begin
      // covers inf and nan too
      f32_mag = FULL_SCALE;
    end else if (f32_ex == 8'd0) begin
      f32_mag = '0;
    end else if (f32_ex >= 8'd119) begin
      f32_mag = {8'd0, f32_m} << f32_lsh;
    end else if (f32_rsh < 8'd24) begin
      f32_mag = {8'd0, f32_m >> f32_rsh[4:0]};
    end else begin
      f32_mag = '0;
    end
  end

  always_comb begin
    f64_ex      = sample_bits_i[62:52];
    f64_m       = {(f64_ex != 11'd0), sample_bits_i[51:0]};
    f64_rsh     = 11'd1044 - f64_ex;
    f64_shifted = f64_m >> f64_rsh[5:0];
    if (f64_ex >= 11'd1023) begin
      f64_mag = FULL_SCALE;
    end else if (f64_ex == 11'd0 || f64_rsh >= 11'd64) begin
      f64_mag = '0;
    end else begin
      f64_mag = f64_shifted[31:0];
    end
  end

  always_comb begin
    dec_item.last = last_value_i;
    dec_item.ok   = 1'b1;
    unique case (sample_format_i)
      FMT_U8:  dec_item.mag = {u8_mag, 24'd0};
      FMT_S16: dec_item.mag = {s16_mag, 16'd0};
      FMT_S32: dec_item.mag = s32_mag;
      FMT_F32: dec_item.mag = f32_mag;
      FMT_F64: dec_item.mag = f64_mag;
      default: begin
        dec_item.mag = '0;
        dec_item.ok  = 1'b0;
      end
    endcase
  end

  assign in_ready_o   = !stg_valid_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = stg_valid_q;
  assign push_item_o  = stg_item_q;

  always_comb begin
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_item_q <= dec_item;
    end
  end

endmodule
`default_nettype wire

[design/apm_fifo.sv]
`default_nettype none
module apm_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  apm_pkg::mag_item_t   push_item_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output apm_pkg::mag_item_t   pop_item_o
);
  import apm_pkg::*;

  mag_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     cnt_q, cnt_d;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

[design/apm_back.sv]
`default_nettype none
module apm_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pop_valid_i,
  output logic                 pop_ready_o,
  input  apm_pkg::mag_item_t   pop_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [31:0]          peak_level_o,
  output logic [16:0]          rms_level_o,
  output logic [16:0]          values_seen_o
);
  import apm_pkg::*;

  back_state_e state_q, state_d;

  mag_item_t          cur_q;
  logic [32:0]        sq_q;
  logic [63:0]        prod;
  logic [31:0]        peak_q;
  logic [48:0]        sum_q;
  logic [16:0]        cnt_q;
  logic [16:0]        rms_q;
  logic [STEP_W-1:0]  step_q;

  // divider
  logic [48:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [17:0] rem_sh;
  logic        div_ge;
  // square root
  logic [33:0] rad_q;
  logic [17:0] r_q, r_d;
  logic [16:0] root_q, root_d;
  logic [19:0] r_sh, trial;
  logic        sqrt_ge;

  logic div_done, root_done;

  assign div_done  = (step_q == STEP_W'(DIV_STEPS - 1));
  assign root_done = (step_q == STEP_W'(SQRT_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (pop_valid_i) state_d = BK_SQUARE;
      BK_SQUARE: state_d = BK_ACC;
      BK_ACC:    state_d = cur_q.last ? BK_PREP : BK_IDLE;
      BK_PREP:   state_d = (cnt_q == '0) ? BK_OUT : BK_DIV;
      BK_DIV:    if (div_done) state_d = BK_ROOT;
      BK_ROOT:   if (root_done) state_d = BK_OUT;
      BK_OUT:    if (out_ready_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = (state_q == BK_IDLE);
    out_valid_o = (state_q == BK_OUT);
  end

  assign peak_level_o  = peak_q;
  assign rms_level_o   = rms_q;
  assign values_seen_o = cnt_q;

  assign prod = cur_q.mag * cur_q.mag;

  // one restoring division bit per cycle
  always_comb begin
    rem_sh = {rem_q, num_q[48]};
    div_ge = (rem_sh >= {1'b0, cnt_q});
    rem_d  = div_ge ? 17'(rem_sh - {1'b0, cnt_q}) : rem_sh[16:0];
    num_d  = {num_q[47:0], div_ge};
  end

  // one root bit per cycle, two radicand bits in
  always_comb begin
    r_sh    = {r_q, rad_q[33:32]};
    trial   = {1'b0, root_q, 2'b01};
    sqrt_ge = (r_sh >= trial);
    r_d     = sqrt_ge ? 18'(r_sh - trial) : r_sh[17:0];
    root_d  = {root_q[15:0], sqrt_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      peak_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      rms_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BK_ACC: begin
          if (cur_q.ok && cnt_q != MAX_VALUES) begin
            if (cur_q.mag > peak_q) begin
              peak_q <= cur_q.mag;
            end
            sum_q <= sum_q + {16'd0, sq_q};
            cnt_q <= cnt_q + 17'd1;
          end
        end
        BK_PREP: begin
          rms_q  <= '0;
          step_q <= '0;
        end
        BK_DIV: begin
          step_q <= div_done ? '0 : step_q + 1'b1;
        end
        BK_ROOT: begin
          step_q <= step_q + 1'b1;
          if (root_done) begin
            rms_q <= root_d;
          end
        end
        BK_OUT: begin
          if (out_ready_i) begin
            peak_q <= '0;
            sum_q  <= '0;
            cnt_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          cur_q <= pop_item_i;
        end
      end
      BK_SQUARE: begin
        sq_q <= prod[62:30];
      end
      BK_PREP: begin
        num_q <= sum_q;
        rem_q <= '0;
      end
      BK_DIV: begin
        num_q <= num_d;
        rem_q <= rem_d;
        if (div_done) begin
          // the mean never exceeds full scale squared, 2^32
          rad_q  <= num_d[33:0];
          r_q    <= '0;
          root_q <= '0;
        end
      end
      BK_ROOT: begin
        rad_q  <= {rad_q[31:0], 2'b00};
        r_q    <= r_d;
        root_q <= root_d;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[design/audio_peak_rms_meter.sv]
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------------------
// samples   | in        | in_valid_i/in_ready_o  | sample_bits_i, last_value_i
// levels    | out       | out_valid_o/out_ready_i| peak_level_o, rms_level_o, values_seen_o
// config    | in        | apb psel/penable/pready| paddr, pwdata, prdata (sample_format)
//
// an item enters the decode register, then a 4-entry queue, and the back end
// takes one item from the queue at a time, going through pop, square and
// accumulate before it takes the next; an item marked last then adds a setup
// state, the divider and the root in the back end (an empty frame skips divide
// and root), then the result waits until it is taken
// the front keeps taking items while the back end is busy, until the queue fills
// reset is asynchronous: format returns to s16 and all sums and counts clear
`default_nettype none
`include "audio_peak_rms_meter_defines.svh"
module audio_peak_rms_meter (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [apm_pkg::PADDR_W-1:0]  paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [63:0]                  sample_bits_i,
  input  wire                          last_value_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [31:0]                  peak_level_o,
  output logic [16:0]                  rms_level_o,
  output logic [16:0]                  values_seen_o
);
  import apm_pkg::*;

  logic [2:0] fmt_q;
  logic       cfg_wr;

  logic       push_valid, push_ready;
  mag_item_t  push_item;
  logic       pop_valid, pop_ready;
  mag_item_t  pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1] == REG_SAMPLE_FORMAT);
  assign prdata = (paddr[PADDR_W-1] == REG_SAMPLE_FORMAT) ? {29'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_S16;
    end else if (cfg_wr) begin
      fmt_q <= pwdata[2:0];
    end
  end

  apm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_format_i (fmt_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_bits_i   (sample_bits_i),
    .last_value_i    (last_value_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  apm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  apm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .peak_level_o  (peak_level_o),
    .rms_level_o   (rms_level_o),
    .values_seen_o (values_seen_o)
  );

  // an empty frame reports zero peak and rms levels
  `APM_ASSERT_IMPLIES(a_empty_frame_zero, out_valid_o && (values_seen_o == 17'd0), (rms_level_o == 17'd0) && (peak_level_o == 32'd0))
  `APM_ASSERT_IMPLIES(a_levels_in_range, out_valid_o, (rms_level_o <= 17'd65536) && (peak_level_o <= FULL_SCALE) && (values_seen_o <= MAX_VALUES))
  // a decoded item still waiting blocks the front only while the queue is full
  `APM_ASSERT_IMPLIES(a_front_stall_on_full, push_valid && !in_ready_o, !push_ready)

endmodule
`default_nettype wire
